>>> hw/rtl/tfnp_pkg.sv
package tfnp_pkg;

  localparam int FRAC_BITS = 13;

  // Width of the integer vectors handed to the normalizer.
  localparam int VW = 64;
  // Q1.30 unit components.
  localparam int QW = 32;
  // Magnitude bits kept after the common shift.
  localparam int TW = 30;

  localparam int NORM_STEPS = 6;
  localparam int SQRT_STEPS = 32;
  localparam int DIV_STEPS  = 31;
  // mag, shifts, square, sum, root, divide setup, divide, sign
  localparam int UNIT_LAT = 1 + NORM_STEPS + 1 + 1 + SQRT_STEPS + 1 + DIV_STEPS + 1;

  localparam logic signed [39:0] THRESH = 40'(99 * (64'd1 << FRAC_BITS));

  typedef struct packed {
    logic signed [15:0] normal_x;
    logic signed [15:0] normal_y;
    logic signed [15:0] normal_z;
    logic signed [15:0] pert_u;
    logic signed [15:0] pert_v;
    logic signed [15:0] pert_n;
  } in_t;

  typedef struct packed {
    logic signed [15:0] out_x;
    logic signed [15:0] out_y;
    logic signed [15:0] out_z;
    logic               degenerate;
  } out_t;

  typedef struct packed {
    logic signed [VW-1:0] x;
    logic signed [VW-1:0] y;
    logic signed [VW-1:0] z;
  } vec_t;

  typedef struct packed {
    logic signed [QW-1:0] x;
    logic signed [QW-1:0] y;
    logic signed [QW-1:0] z;
  } uvec_t;

  // Data that rides alongside a vector through the normalizer.
  typedef struct packed {
    in_t   item;
    uvec_t v;
    logic  degenerate;
  } side_t;

endpackage

>>> hw/rtl/tfnp_unit.sv
module tfnp_unit (
  input  logic            clk,
  input  logic            rst,
  input  logic            en,
  input  logic            vin,
  input  tfnp_pkg::vec_t  vec,
  input  tfnp_pkg::side_t side_in,
  output logic            vout,
  output tfnp_pkg::uvec_t unit,
  output logic            zero,
  output tfnp_pkg::side_t side_out
);
  import tfnp_pkg::*;

  typedef struct packed {
    side_t      side;
    logic [2:0] neg;
    logic       zero;
  } carry_t;

  logic   vld   [UNIT_LAT];
  carry_t carry [UNIT_LAT];

  logic [VW-1:0] nm   [NORM_STEPS+1][3];
  logic [VW-1:0] nor_w[NORM_STEPS+1];

  logic [TW-1:0]   t7 [3];
  logic [2*TW-1:0] sq [3];

  logic [63:0]   sx [SQRT_STEPS+1];
  logic [63:0]   sr [SQRT_STEPS+1];
  logic [TW-1:0] ts [SQRT_STEPS+1][3];

  logic [31:0]          rem  [DIV_STEPS+1][3];
  logic [DIV_STEPS-1:0] low  [DIV_STEPS+1][3];
  logic [DIV_STEPS-1:0] quo  [DIV_STEPS+1][3];
  logic [31:0]          dd   [DIV_STEPS+1];

  logic [VW-1:0] mag_in [3];
  logic [60:0]   numer  [3];

  assign mag_in[0] = vec.x[VW-1] ? VW'(-vec.x) : VW'(vec.x);
  assign mag_in[1] = vec.y[VW-1] ? VW'(-vec.y) : VW'(vec.y);
  assign mag_in[2] = vec.z[VW-1] ? VW'(-vec.z) : VW'(vec.z);

  // Valid bits.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < UNIT_LAT; k++) vld[k] <= 1'b0;
    end else if (en) begin
      vld[0] <= vin;
      for (int k = 1; k < UNIT_LAT; k++) vld[k] <= vld[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      carry[0].side <= side_in;
      carry[0].neg  <= {vec.z[VW-1], vec.y[VW-1], vec.x[VW-1]};
      carry[0].zero <= (vec.x == '0) && (vec.y == '0) && (vec.z == '0);
      for (int k = 1; k < UNIT_LAT; k++) carry[k] <= carry[k-1];
      for (int i = 0; i < 3; i++) nm[0][i] <= mag_in[i];
      nor_w[0] <= mag_in[0] | mag_in[1] | mag_in[2];
    end
  end

  // Left shifts that bring the top set bit of the largest magnitude to the
  // top of the word; the OR of the magnitudes has the same top bit.
  for (genvar s = 0; s < NORM_STEPS; s++) begin : g_norm
    localparam int SH = (VW / 2) >> s;
    always_ff @(posedge clk) begin
      if (en) begin
        if (nor_w[s][VW-1 -: SH] == '0) begin
          nor_w[s+1] <= nor_w[s] << SH;
          for (int i = 0; i < 3; i++) nm[s+1][i] <= nm[s][i] << SH;
        end else begin
          nor_w[s+1] <= nor_w[s];
          for (int i = 0; i < 3; i++) nm[s+1][i] <= nm[s][i];
        end
      end
    end
  end

  // The top bits now hold each magnitude scaled so the largest is in
  // [2^29, 2^30), truncated where the scale is a right shift.
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        t7[i] <= nm[NORM_STEPS][i][VW-1 -: TW];
        sq[i] <= nm[NORM_STEPS][i][VW-1 -: TW] * nm[NORM_STEPS][i][VW-1 -: TW];
      end
      sx[0] <= 64'(sq[0]) + 64'(sq[1]) + 64'(sq[2]);
      sr[0] <= '0;
      for (int i = 0; i < 3; i++) ts[0][i] <= t7[i];
    end
  end

  for (genvar j = 0; j < SQRT_STEPS; j++) begin : g_sqrt
    localparam logic [63:0] B = 64'd1 << (62 - 2 * j);
    always_ff @(posedge clk) begin
      if (en) begin
        if (sx[j] >= sr[j] + B) begin
          sx[j+1] <= sx[j] - (sr[j] + B);
          sr[j+1] <= (sr[j] >> 1) + B;
        end else begin
          sx[j+1] <= sx[j];
          sr[j+1] <= sr[j] >> 1;
        end
        for (int i = 0; i < 3; i++) ts[j+1][i] <= ts[j][i];
      end
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      numer[i] = {1'b0, ts[SQRT_STEPS][i], 30'd0} + 61'(sr[SQRT_STEPS][31:1]);
    end
  end

  // The quotient is known to fit in DIV_STEPS bits, so the upper numerator
  // bits start out below the divisor.
  always_ff @(posedge clk) begin
    if (en) begin
      dd[0] <= sr[SQRT_STEPS][31:0];
      for (int i = 0; i < 3; i++) begin
        rem[0][i] <= 32'(numer[i][60:DIV_STEPS]);
        low[0][i] <= numer[i][DIV_STEPS-1:0];
        quo[0][i] <= '0;
      end
    end
  end

  for (genvar j = 0; j < DIV_STEPS; j++) begin : g_div
    always_ff @(posedge clk) begin
      logic [32:0] rt;
      if (en) begin
        dd[j+1] <= dd[j];
        for (int i = 0; i < 3; i++) begin
          rt = {rem[j][i], low[j][i][DIV_STEPS-1]};
          if (rt >= {1'b0, dd[j]}) begin
            rem[j+1][i] <= 32'(rt - {1'b0, dd[j]});
            quo[j+1][i] <= {quo[j][i][DIV_STEPS-2:0], 1'b1};
          end else begin
            rem[j+1][i] <= rt[31:0];
            quo[j+1][i] <= {quo[j][i][DIV_STEPS-2:0], 1'b0};
          end
          low[j+1][i] <= low[j][i] << 1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      unit.x <= carry[UNIT_LAT-2].neg[0] ? -QW'(quo[DIV_STEPS][0]) : QW'(quo[DIV_STEPS][0]);
      unit.y <= carry[UNIT_LAT-2].neg[1] ? -QW'(quo[DIV_STEPS][1]) : QW'(quo[DIV_STEPS][1]);
      unit.z <= carry[UNIT_LAT-2].neg[2] ? -QW'(quo[DIV_STEPS][2]) : QW'(quo[DIV_STEPS][2]);
    end
  end

  assign vout     = vld[UNIT_LAT-1];
  assign zero     = carry[UNIT_LAT-1].zero;
  assign side_out = carry[UNIT_LAT-1].side;

endmodule

>>> hw/rtl/tangent_frame_normal_perturb.sv
// Throughput: one beat per cycle unless the result side stalls; each of
// the three normalizers is a fully pipelined 74-stage unit with a
// bit-per-stage square root and divider.
// A stall on the result side holds the whole pipeline in place.
// Reset (rst, synchronous) clears all valid bits; payload is not reset.
module tangent_frame_normal_perturb (
  input  logic           clk,
  input  logic           rst,
  input  logic           norm_valid,
  output logic           norm_stall,
  input  tfnp_pkg::in_t  norm_data,
  output logic           res_valid,
  input  logic           res_stall,
  output tfnp_pkg::out_t res_data
);
  import tfnp_pkg::*;

  logic en;
  assign en         = !(res_valid && res_stall);
  assign norm_stall = !en;

  logic signed [39:0] z100;
  assign z100 = 40'(norm_data.normal_z) * 40'sd100;

  logic a_vld, b_vld, c_vld, d_vld, e_vld;
  in_t  a_item, b_item, c_item, d_item;
  logic a_hi;

  logic signed [16:0] pvx, pvy, pvz;
  logic signed [16:0] b_pvx, b_pvy, b_pvz;
  logic signed [32:0] b_p [6];
  logic signed [16:0] c_pvx, c_pvy, c_pvz;
  logic signed [33:0] c_cx, c_cy, c_cz;

  always_comb begin
    if (a_hi) begin
      pvx = '0;
      pvy = -17'(a_item.normal_z);
      pvz = 17'(a_item.normal_y);
    end else begin
      pvx = 17'(a_item.normal_y);
      pvy = -17'(a_item.normal_x);
      pvz = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_vld <= 1'b0;
      b_vld <= 1'b0;
      c_vld <= 1'b0;
    end else if (en) begin
      a_vld <= norm_valid;
      b_vld <= a_vld;
      c_vld <= b_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_item <= norm_data;
      a_hi   <= (z100 > THRESH) || (z100 < -THRESH);
      b_item <= a_item;
      b_pvx  <= pvx;
      b_pvy  <= pvy;
      b_pvz  <= pvz;
      b_p[0] <= 33'(a_item.normal_y) * 33'(pvz);
      b_p[1] <= 33'(a_item.normal_z) * 33'(pvy);
      b_p[2] <= 33'(a_item.normal_z) * 33'(pvx);
      b_p[3] <= 33'(a_item.normal_x) * 33'(pvz);
      b_p[4] <= 33'(a_item.normal_x) * 33'(pvy);
      b_p[5] <= 33'(a_item.normal_y) * 33'(pvx);
      c_item <= b_item;
      c_pvx  <= b_pvx;
      c_pvy  <= b_pvy;
      c_pvz  <= b_pvz;
      c_cx   <= 34'(b_p[0]) - 34'(b_p[1]);
      c_cy   <= 34'(b_p[2]) - 34'(b_p[3]);
      c_cz   <= 34'(b_p[4]) - 34'(b_p[5]);
    end
  end

  // Both tangents come from integer vectors, so their normalizers run
  // side by side.
  vec_t  pv_vec, c_vec, o_vec;
  side_t c_side, v_side, r_side, e_side;
  uvec_t v_unit, u_unit, r_unit;
  logic  v_vld, u_vld, r_vld, v_zero, u_zero, r_zero;

  assign pv_vec = '{x: VW'(c_pvx), y: VW'(c_pvy), z: VW'(c_pvz)};
  assign c_vec  = '{x: VW'(c_cx), y: VW'(c_cy), z: VW'(c_cz)};
  assign c_side = '{item: c_item, v: '0, degenerate: 1'b0};

  tfnp_unit u_vnorm (
    .clk(clk), .rst(rst), .en(en), .vin(c_vld), .vec(pv_vec), .side_in(c_side),
    .vout(v_vld), .unit(v_unit), .zero(v_zero), .side_out(v_side)
  );

  tfnp_unit u_unorm (
    .clk(clk), .rst(rst), .en(en), .vin(c_vld), .vec(c_vec), .side_in(c_side),
    .vout(u_vld), .unit(u_unit), .zero(u_zero), .side_out()
  );

  logic signed [31:0] d_np [3];
  logic signed [47:0] d_up [3];
  logic signed [47:0] d_vp [3];
  logic               d_deg;
  logic signed [15:0] d_n  [3];
  logic signed [15:0] dn   [3];
  logic signed [QW-1:0] uu [3];
  logic signed [QW-1:0] vv [3];

  assign dn[0] = v_side.item.normal_x;
  assign dn[1] = v_side.item.normal_y;
  assign dn[2] = v_side.item.normal_z;
  assign uu[0] = u_unit.x;
  assign uu[1] = u_unit.y;
  assign uu[2] = u_unit.z;
  assign vv[0] = v_unit.x;
  assign vv[1] = v_unit.y;
  assign vv[2] = v_unit.z;

  logic signed [VW-1:0] osum [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      d_vld <= 1'b0;
      e_vld <= 1'b0;
    end else if (en) begin
      d_vld <= v_vld && u_vld;
      e_vld <= d_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_item <= v_side.item;
      d_deg  <= v_zero || u_zero;
      for (int i = 0; i < 3; i++) begin
        d_n[i]  <= dn[i];
        d_np[i] <= 32'(dn[i]) * 32'(v_side.item.pert_n);
        d_up[i] <= 48'(uu[i]) * 48'(v_side.item.pert_u);
        d_vp[i] <= 48'(vv[i]) * 48'(v_side.item.pert_v);
      end
      for (int i = 0; i < 3; i++) begin
        osum[i] <= (VW'(d_n[i]) <<< 30) + (VW'(d_np[i]) <<< (30 - FRAC_BITS))
                 + VW'(d_up[i]) + VW'(d_vp[i]);
      end
      e_side <= '{item: d_item, v: '0, degenerate: d_deg};
    end
  end

  assign o_vec = '{x: osum[0], y: osum[1], z: osum[2]};

  tfnp_unit u_rnorm (
    .clk(clk), .rst(rst), .en(en), .vin(e_vld), .vec(o_vec), .side_in(e_side),
    .vout(r_vld), .unit(r_unit), .zero(r_zero), .side_out(r_side)
  );

  function automatic logic signed [15:0] to_q14(input logic signed [QW-1:0] v);
    logic [QW-1:0] m;
    logic [QW-1:0] q;
    m = v[QW-1] ? QW'(-v) : QW'(v);
    q = (m + (QW'(1) << 15)) >> 16;
    if (q > QW'(16384)) q = QW'(16384);
    return v[QW-1] ? -16'(q) : 16'(q);
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (en) begin
      res_valid <= r_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (r_side.degenerate || r_zero) begin
        res_data <= '{out_x: '0, out_y: '0, out_z: '0, degenerate: 1'b1};
      end else begin
        res_data <= '{out_x: to_q14(r_unit.x), out_y: to_q14(r_unit.y),
                      out_z: to_q14(r_unit.z), degenerate: 1'b0};
      end
    end
  end

`ifndef SYNTH
  a_deg_zero: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_data.degenerate |->
      res_data.out_x == 0 && res_data.out_y == 0 && res_data.out_z == 0)
    else $error("degenerate result with nonzero components");

  a_range: assert property (@(posedge clk) disable iff (rst)
    res_valid |->
      res_data.out_x >= -16384 && res_data.out_x <= 16384 &&
      res_data.out_y >= -16384 && res_data.out_y <= 16384 &&
      res_data.out_z >= -16384 && res_data.out_z <= 16384)
    else $error("result component out of range");

  a_unit_nonzero: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_data.degenerate |->
      res_data.out_x != 0 || res_data.out_y != 0 || res_data.out_z != 0)
    else $error("unit result is the zero vector");

  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !res_valid)
    else $error("result valid right after reset");
`endif

endmodule
